>>> design/cpbc_pkg.sv
// ----------------------------------------------------------------------------
// cpbc_pkg
// Types and constants shared by the close-page bank controller modules.
// ----------------------------------------------------------------------------
package cpbc_pkg;

  localparam int ADDR_W      = 48;
  localparam int OFFSET_BITS = 6;
  localparam int REST_W      = ADDR_W - OFFSET_BITS;
  localparam int COLUMN_MAX  = 16;
  localparam int ROW_MAX     = 24;
  localparam int COUNT_W     = 5;
  localparam int CYCLE_W     = 32;
  localparam int SHIFT_W     = 6;
  localparam int BANK_FLD_W  = 3;

  typedef enum logic [2:0] {
    CMD_ACTIVATE   = 3'd0,
    CMD_READ       = 3'd1,
    CMD_WRITE      = 3'd2,
    CMD_PRECHARGE  = 3'd3,
    CMD_CLOSE_WAIT = 3'd4,
    CMD_NONE       = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_COLUMN_BITS    = 3'd0,
    REG_ROW_BITS       = 3'd1,
    REG_BANK_BITS      = 3'd2,
    REG_WAY_BITS       = 3'd3,
    REG_CHANNEL_BITS   = 3'd4,
    REG_ACTIVATE_DELAY = 3'd5,
    REG_COLUMN_DELAY   = 3'd6,
    REG_CLOSE_DELAY    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              has_request;
    logic              is_write;
    logic [ADDR_W-1:0] request_address;
  } tick_t;

  typedef struct packed {
    cmd_t               issued_command;
    logic               done_res;
    logic               done_is_write;
    logic [ADDR_W-1:0]  done_address;
    logic               dropped;
    logic [COUNT_W-1:0] queue_count;
    logic [CYCLE_W-1:0] cycle;
  } result_t;

  typedef struct packed {
    logic [4:0] column_bits;
    logic [4:0] row_bits;
    logic [1:0] bank_bits;
    logic       way_bits;
    logic       channel_bits;
    logic [7:0] activate_delay;
    logic [7:0] column_delay;
    logic [7:0] close_delay;
  } cfg_t;

  typedef struct packed {
    logic                  is_write;
    logic [ADDR_W-1:0]     address;
    logic                  channel;
    logic                  way;
    logic [BANK_FLD_W-1:0] bank;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic               dropped;
    logic [COUNT_W-1:0] queue_count;
  } front_res_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               done_res;
    logic               done_is_write;
    logic [ADDR_W-1:0]  done_address;
    logic [CYCLE_W-1:0] cycle;
  } back_res_t;

endpackage

>>> design/close_page_bank_controller_top.sv
// ----------------------------------------------------------------------------
// close_page_bank_controller_top
// One tick accepted per cycle while tick_ready is high; its result enters a two-entry
// registered output buffer and is offered from it behind any older result still held.
// Throughput one tick per cycle while the output buffer has room; the bank sequencer steps once per accepted tick.
// Ticks stall only while both output buffer entries are full.
// Synchronous reset clears queue, bank state, cycle counter and output buffer,
// and restores the register defaults.
// ----------------------------------------------------------------------------
module close_page_bank_controller_top
  import cpbc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CHANNELS    = 2,
  parameter int WAYS        = 2,
  parameter int BANKS       = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_ready,
  input  tick_t       tick,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  head_t      head;
  front_res_t front_res;
  back_res_t  back_res;
  logic       pop;
  logic       fire;
  logic       take;
  logic       cfg_wr;
  reg_idx_t   reg_idx;
  result_t    obuf [2];
  result_t    beat;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] ocnt;
  logic [1:0] ocnt_next;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_bits    <= 5'd3;
      cfg.row_bits       <= 5'd2;
      cfg.bank_bits      <= 2'd0;
      cfg.way_bits       <= 1'b0;
      cfg.channel_bits   <= 1'b0;
      cfg.activate_delay <= 8'd11;
      cfg.column_delay   <= 8'd11;
      cfg.close_delay    <= 8'd39;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COLUMN_BITS:    cfg.column_bits    <= pwdata[4:0];
        REG_ROW_BITS:       cfg.row_bits       <= pwdata[4:0];
        REG_BANK_BITS:      cfg.bank_bits      <= pwdata[1:0];
        REG_WAY_BITS:       cfg.way_bits       <= pwdata[0];
        REG_CHANNEL_BITS:   cfg.channel_bits   <= pwdata[0];
        REG_ACTIVATE_DELAY: cfg.activate_delay <= pwdata[7:0];
        REG_COLUMN_DELAY:   cfg.column_delay   <= pwdata[7:0];
        REG_CLOSE_DELAY:    cfg.close_delay    <= pwdata[7:0];
        default:            cfg.close_delay    <= cfg.close_delay;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COLUMN_BITS:    prdata = 32'(cfg.column_bits);
      REG_ROW_BITS:       prdata = 32'(cfg.row_bits);
      REG_BANK_BITS:      prdata = 32'(cfg.bank_bits);
      REG_WAY_BITS:       prdata = 32'(cfg.way_bits);
      REG_CHANNEL_BITS:   prdata = 32'(cfg.channel_bits);
      REG_ACTIVATE_DELAY: prdata = 32'(cfg.activate_delay);
      REG_COLUMN_DELAY:   prdata = 32'(cfg.column_delay);
      REG_CLOSE_DELAY:    prdata = 32'(cfg.close_delay);
      default:            prdata = '0;
    endcase
  end

  assign tick_ready   = (ocnt != 2'd2);
  assign fire         = tick_valid && tick_ready;
  assign result_valid = (ocnt != 2'd0);
  assign take         = result_valid && result_ready;
  assign result       = obuf[rd_ptr];
  assign ocnt_next    = ocnt + 2'(fire) - 2'(take);

  cpbc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CHANNELS    (CHANNELS),
    .WAYS        (WAYS),
    .BANKS       (BANKS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .tick (tick),
    .cfg  (cfg),
    .pop  (pop),
    .head (head),
    .res  (front_res)
  );

  cpbc_back u_back (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .head (head),
    .cfg  (cfg),
    .pop  (pop),
    .res  (back_res)
  );

  always_comb begin
    beat.issued_command = back_res.cmd;
    beat.done_res       = back_res.done_res;
    beat.done_is_write  = back_res.done_is_write;
    beat.done_address   = back_res.done_address;
    beat.dropped        = front_res.dropped;
    beat.queue_count    = front_res.queue_count;
    beat.cycle          = back_res.cycle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      if (fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      ocnt <= ocnt_next;
    end
    if (fire) begin
      obuf[wr_ptr] <= beat;
    end
  end

endmodule

>>> design/cpbc_front.sv
// ----------------------------------------------------------------------------
// cpbc_front
// Request intake: address split, request queue with drop on full, head view.
// ----------------------------------------------------------------------------
module cpbc_front
  import cpbc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CHANNELS    = 2,
  parameter int WAYS        = 2,
  parameter int BANKS       = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  tick_t      tick,
  input  cfg_t       cfg,
  input  logic       pop,
  output head_t      head,
  output front_res_t res
);

  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int BANK_LOG = $clog2(BANKS + 1) - 1;
  localparam int WAY_LOG  = $clog2(WAYS + 1) - 1;
  localparam int CHAN_LOG = $clog2(CHANNELS + 1) - 1;

  entry_t             mem [QUEUE_DEPTH];
  entry_t             head_q;
  entry_t             new_entry;
  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   tail_ptr;
  logic [PTR_W-1:0]   head_ptr_next;
  logic [PTR_W-1:0]   tail_ptr_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               full;
  logic               enq;
  logic [4:0]         col_c;
  logic [4:0]         row_c;
  logic [SHIFT_W-1:0] shift;
  logic [REST_W-1:0]  rest;
  logic [REST_W-1:0]  r1;
  logic [REST_W-1:0]  r2;
  logic [REST_W-1:0]  r3;
  logic [2:0]         bank_c;
  logic               way_c;
  logic               chan_c;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    col_c  = (cfg.column_bits > 5'(COLUMN_MAX)) ? 5'(COLUMN_MAX) : cfg.column_bits;
    row_c  = (cfg.row_bits > 5'(ROW_MAX)) ? 5'(ROW_MAX) : cfg.row_bits;
    shift  = {1'b0, col_c} + {1'b0, row_c};
    rest   = tick.request_address[ADDR_W-1:OFFSET_BITS];
    r1     = rest >> shift;
    bank_c = ({1'b0, cfg.bank_bits} > 3'(BANK_LOG)) ? 3'(BANK_LOG) : {1'b0, cfg.bank_bits};
    r2     = r1 >> bank_c;
    way_c  = (WAY_LOG > 0) ? cfg.way_bits : 1'b0;
    r3     = r2 >> way_c;
    chan_c = (CHAN_LOG > 0) ? cfg.channel_bits : 1'b0;

    new_entry.is_write = tick.is_write;
    new_entry.address  = tick.request_address;
    new_entry.bank     = r1[BANK_FLD_W-1:0] & ((3'd1 << bank_c) - 3'd1);
    new_entry.way      = r2[0] & way_c;
    new_entry.channel  = r3[0] & chan_c;
  end

  always_comb begin
    full          = (count == CNT_W'(QUEUE_DEPTH));
    enq           = fire && tick.has_request && !full;
    head.valid    = (count != '0) || enq;
    head.entry    = (count == '0) ? new_entry : head_q;
    count_next    = count + CNT_W'(enq) - CNT_W'(pop);
    tail_ptr_next = enq ? wrap_inc(tail_ptr) : tail_ptr;
    head_ptr_next = pop ? wrap_inc(head_ptr) : head_ptr;
    res.dropped     = fire && tick.has_request && full;
    res.queue_count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      count    <= '0;
    end else if (fire) begin
      head_ptr <= head_ptr_next;
      tail_ptr <= tail_ptr_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[tail_ptr] <= new_entry;
    end
    if (enq && (tail_ptr == head_ptr_next)) begin
      head_q <= new_entry;
    end else begin
      head_q <= mem[head_ptr_next];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop with no head request");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("queue count moved without a beat");

endmodule

>>> design/cpbc_back.sv
// ----------------------------------------------------------------------------
// cpbc_back
// Bank sequencer: serves the head request through activate, column access,
// precharge and close wait, with timing checks against the cycle counter.
// ----------------------------------------------------------------------------
module cpbc_back
  import cpbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  head_t     head,
  input  cfg_t      cfg,
  output logic      pop,
  output back_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ACT  = 3'd1,
    PH_RD   = 3'd2,
    PH_WR   = 3'd3,
    PH_PRE  = 3'd4
  } phase_t;

  phase_t                phase;
  phase_t                phase_next;
  logic [CYCLE_W-1:0]    cycle_count;
  logic [CYCLE_W-1:0]    cycle_count_next;
  logic [CYCLE_W-1:0]    col_time;
  logic [CYCLE_W-1:0]    col_time_next;
  logic [CYCLE_W-1:0]    pre_time;
  logic [CYCLE_W-1:0]    pre_time_next;
  logic [CYCLE_W-1:0]    idle_time;
  logic [CYCLE_W-1:0]    idle_time_next;
  logic [BANK_FLD_W-1:0] act_bank;
  logic [BANK_FLD_W-1:0] act_bank_next;
  logic                  act_way;
  logic                  act_way_next;
  logic                  act_channel;
  logic                  act_channel_next;
  logic                  done;
  logic [8:0]            pre_delay;

  always_comb begin
    phase_next       = phase;
    col_time_next    = col_time;
    pre_time_next    = pre_time;
    idle_time_next   = idle_time;
    act_bank_next    = act_bank;
    act_way_next     = act_way;
    act_channel_next = act_channel;
    done             = 1'b0;
    res.cmd          = CMD_NONE;
    pre_delay        = {1'b0, cfg.activate_delay} + {1'b0, cfg.column_delay};
    if (head.valid) begin
      unique case (phase)
        PH_ACT: begin
          res.cmd = head.entry.is_write ? CMD_WRITE : CMD_READ;
          if (col_time <= cycle_count) begin
            phase_next = head.entry.is_write ? PH_WR : PH_RD;
          end
        end
        PH_RD, PH_WR: begin
          res.cmd = CMD_PRECHARGE;
          if (pre_time <= cycle_count) begin
            phase_next = PH_PRE;
          end
        end
        PH_PRE: begin
          res.cmd = CMD_CLOSE_WAIT;
          if (idle_time <= cycle_count) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        default: begin
          res.cmd          = CMD_ACTIVATE;
          phase_next       = PH_ACT;
          idle_time_next   = cycle_count + CYCLE_W'(cfg.close_delay);
          col_time_next    = cycle_count + CYCLE_W'(cfg.activate_delay);
          pre_time_next    = cycle_count + CYCLE_W'(pre_delay);
          act_bank_next    = head.entry.bank;
          act_way_next     = head.entry.way;
          act_channel_next = head.entry.channel;
        end
      endcase
    end
    cycle_count_next  = done ? cycle_count : cycle_count + CYCLE_W'(1);
    pop               = fire && done;
    res.done_res      = done;
    res.done_is_write = done && head.entry.is_write;
    res.done_address  = done ? head.entry.address : '0;
    res.cycle         = cycle_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cycle_count <= '0;
      col_time    <= '0;
      pre_time    <= '0;
      idle_time   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      cycle_count <= cycle_count_next;
      col_time    <= col_time_next;
      pre_time    <= pre_time_next;
      idle_time   <= idle_time_next;
    end
    if (fire) begin
      act_bank    <= act_bank_next;
      act_way     <= act_way_next;
      act_channel <= act_channel_next;
    end
  end

  a_busy_has_head: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> head.valid)
    else $error("bank busy with empty queue");

  a_busy_same_bank: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (head.entry.bank == act_bank && head.entry.way == act_way &&
                            head.entry.channel == act_channel))
    else $error("head request moved off the open bank");

  a_done_holds_cycle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (cycle_count == $past(cycle_count)) && (phase == PH_IDLE))
    else $error("completion did not hold the cycle counter");

endmodule
